### rtl/core/stid_pkg.sv
// Shared types and constants for the sorted table insert/delete block.
`timescale 1ns / 1ps

package stid_pkg;

  localparam int unsigned DEPTH = 128;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned VW    = 32;
  localparam int unsigned PW    = 8;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CHECK
  } state_e;

  typedef struct packed {
    logic                 action;
    logic signed [VW-1:0] value;
  } req_t;

  typedef struct packed {
    status_e       status;
    logic [PW-1:0] position;
    logic [PW-1:0] entry_count;
  } res_t;

endpackage

### rtl/core/sorted_table_insert_delete_top.sv
// Top level of the sorted table: descending value store with insert and delete.
//
//   channel   | signals                    | handshake
//   ----------+----------------------------+-------------------------------------
//   request   | start_i, req_i, busy_o     | beat taken when start_i & !busy_o
//   result    | res_valid_o, res_o         | one-cycle strobe, cannot be held off
//
// An insert walks the table from the end down, one entry at a time (memory read,
// then compare and write back), moving each smaller entry up one place. A delete
// walks the whole table once from the start, finding the value and moving later
// entries down. A full-table insert is answered straight from idle, with no walk.
// The pace of each walk is set by the single read port of the entry RAM.
// Reset empties the table at once; entry contents need no clearing.
`timescale 1ns / 1ps

module sorted_table_insert_delete_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  stid_pkg::req_t req_i,
  output logic          busy_o,
  output logic          res_valid_o,
  output stid_pkg::res_t res_o
);

  import stid_pkg::*;

  state_e        state_q, state_d;
  req_t          req_q, req_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] pos_q, pos_d;
  logic          found_q, found_d;
  res_t          res_q, res_d;
  logic          res_valid_q, res_valid_d;

  logic [CW-1:0] ptr_dec, ptr_inc;
  logic          fin;
  status_e       fin_status;
  logic [CW-1:0] fin_pos, fin_cnt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [VW-1:0] wdata, rd_data;

  stid_ram #(
    .WIDTH(VW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rd_data)
  );

  assign ptr_dec = ptr_q - 1'b1;
  assign ptr_inc = ptr_q + 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i && !fin) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = fin ? S_IDLE : S_CHECK;
      end
      S_CHECK: begin
        state_d = fin ? S_IDLE : S_READ;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    req_d      = req_q;
    ptr_d      = ptr_q;
    pos_d      = pos_q;
    found_d    = found_q;
    we         = 1'b0;
    waddr      = '0;
    wdata      = rd_data;
    raddr      = '0;
    fin        = 1'b0;
    fin_status = ST_DONE;
    fin_pos    = '0;
    fin_cnt    = cnt_q;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d   = req_i;
          found_d = 1'b0;
          pos_d   = '0;
          ptr_d   = (req_i.action == ACT_INSERT) ? cnt_q : '0;
          if (req_i.action == ACT_INSERT && cnt_q == CW'(DEPTH)) begin
            fin        = 1'b1;
            fin_status = ST_FULL;
          end
        end
      end
      S_READ: begin
        if (req_q.action == ACT_INSERT) begin
          if (ptr_q == '0) begin
            // every stored value is smaller, or the table is empty: write at the front
            we      = 1'b1;
            waddr   = '0;
            wdata   = req_q.value;
            fin     = 1'b1;
            fin_cnt = cnt_q + 1'b1;
          end else begin
            raddr = ptr_dec[AW-1:0];
          end
        end else begin
          if (ptr_q == cnt_q) begin
            fin = 1'b1;
            if (found_q) begin
              fin_pos = pos_q;
              fin_cnt = cnt_q - 1'b1;
            end else begin
              fin_status = ST_MISSING;
            end
          end else begin
            raddr = ptr_q[AW-1:0];
          end
        end
      end
      S_CHECK: begin
        if (req_q.action == ACT_INSERT) begin
          we    = 1'b1;
          waddr = ptr_q[AW-1:0];
          if (req_q.value > $signed(rd_data)) begin
            // move the smaller entry up and keep walking down
            wdata = rd_data;
            ptr_d = ptr_dec;
          end else begin
            wdata   = req_q.value;
            fin     = 1'b1;
            fin_pos = ptr_q;
            fin_cnt = cnt_q + 1'b1;
          end
        end else begin
          if (found_q) begin
            we    = 1'b1;
            waddr = ptr_dec[AW-1:0];
          end else if (req_q.value == $signed(rd_data)) begin
            found_d = 1'b1;
            pos_d   = ptr_q;
          end
          ptr_d = ptr_inc;
        end
      end
      default: ;
    endcase

    res_valid_d = fin;
    cnt_d       = fin ? fin_cnt : cnt_q;
    res_d       = res_q;
    if (fin) begin
      res_d.status      = fin_status;
      res_d.position    = PW'(fin_pos);
      res_d.entry_count = PW'(fin_cnt);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    ptr_q   <= ptr_d;
    pos_q   <= pos_d;
    found_q <= found_d;
    res_q   <= res_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### rtl/core/stid_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module stid_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### bench/sorted_table_insert_delete_top_tb.sv
// Self-checking testbench for the descending sorted table with insert and delete.
`timescale 1ns / 1ps

module sorted_table_insert_delete_top_tb;
  import stid_pkg::*;

  localparam int N_DIR       = 20;
  localparam int N_PHASE     = 4;
  localparam int PHASE_BEATS = 500;
  localparam int DRAIN_WAIT  = 2 * DEPTH + 8;
  localparam int CYCLE_LIMIT = 4_000_000;

  typedef struct {
    logic          act;
    logic [VW-1:0] val;
    bit            known;
    status_e       st;
    logic [PW-1:0] pos;
    logic [PW-1:0] cnt;
  } dir_row_t;

  // Rows marked known carry a result that follows directly from an empty table.
  dir_row_t dir_tab [N_DIR] = '{
    '{ACT_DELETE, 32'h0000_0000, 1'b1, ST_MISSING, 8'd0, 8'd0},
    '{ACT_DELETE, 32'h8000_0000, 1'b1, ST_MISSING, 8'd0, 8'd0},
    '{ACT_INSERT, 32'h0000_0000, 1'b1, ST_DONE,    8'd0, 8'd1},
    '{ACT_INSERT, 32'h7FFF_FFFF, 1'b1, ST_DONE,    8'd0, 8'd2},
    '{ACT_INSERT, 32'h8000_0000, 1'b1, ST_DONE,    8'd2, 8'd3},
    '{ACT_INSERT, 32'h0000_0000, 1'b0, ST_DONE,    8'd0, 8'd0},
    '{ACT_INSERT, 32'h8000_0000, 1'b0, ST_DONE,    8'd0, 8'd0},
    '{ACT_INSERT, 32'hFFFF_FFFF, 1'b0, ST_DONE,    8'd0, 8'd0},
    '{ACT_INSERT, 32'h0000_0001, 1'b0, ST_DONE,    8'd0, 8'd0},
    '{ACT_INSERT, 32'hAAAA_AAAA, 1'b0, ST_DONE,    8'd0, 8'd0},
    '{ACT_INSERT, 32'h5555_5555, 1'b0, ST_DONE,    8'd0, 8'd0},
    '{ACT_DELETE, 32'h1234_5678, 1'b0, ST_DONE,    8'd0, 8'd0},
    '{ACT_DELETE, 32'h7FFF_FFFF, 1'b0, ST_DONE,    8'd0, 8'd0},
    '{ACT_DELETE, 32'h0000_0000, 1'b0, ST_DONE,    8'd0, 8'd0},
    '{ACT_DELETE, 32'h8000_0000, 1'b0, ST_DONE,    8'd0, 8'd0},
    '{ACT_DELETE, 32'h8000_0000, 1'b0, ST_DONE,    8'd0, 8'd0},
    '{ACT_INSERT, 32'h7FFF_FFFF, 1'b0, ST_DONE,    8'd0, 8'd0},
    '{ACT_INSERT, 32'h7FFF_FFFF, 1'b0, ST_DONE,    8'd0, 8'd0},
    '{ACT_DELETE, 32'hAAAA_AAAA, 1'b0, ST_DONE,    8'd0, 8'd0},
    '{ACT_DELETE, 32'h5555_5555, 1'b0, ST_DONE,    8'd0, 8'd0}
  };

  localparam int PHASE_IDLE [N_PHASE] = '{0, 65, 22, 0};
  localparam logic [VW-1:0] EDGE_VALS [4] =
    '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic start_i = 1'b0;
  req_t req_i   = '0;
  logic busy_o;
  logic res_valid_o;
  res_t res_o;

  // Shadow copy of the table, advanced once per accepted beat
  logic signed [VW-1:0] shadow_tbl [DEPTH];
  int                   shadow_cnt = 0;
  res_t                 pending_res_q [$];

  int idle_pct    = 0;
  int mismatches  = 0;
  int cycles      = 0;
  int n_insert    = 0;
  int n_delete    = 0;
  int n_full      = 0;
  int n_missing   = 0;
  int peak_cnt    = 0;

  sorted_table_insert_delete_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               pending_res_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Apply one beat to the shadow table and return the result it should produce.
  function automatic res_t table_apply(req_t r);
    res_t                 o;
    int                   pos;
    bit                   hit;
    logic signed [VW-1:0] v;
    v        = $signed(r.value);
    o.status = ST_DONE;
    pos      = 0;
    hit      = 1'b0;
    if (r.action == ACT_INSERT) begin
      if (shadow_cnt >= DEPTH) begin
        o.status = ST_FULL;
      end else begin
        pos = shadow_cnt;
        for (int i = 0; i < shadow_cnt; i++) begin
          if (v > shadow_tbl[i]) begin
            pos = i;
            break;
          end
        end
        for (int i = shadow_cnt; i > pos; i--) shadow_tbl[i] = shadow_tbl[i-1];
        shadow_tbl[pos] = v;
        shadow_cnt++;
      end
    end else begin
      for (int i = 0; i < shadow_cnt; i++) begin
        if (shadow_tbl[i] == v) begin
          pos = i;
          hit = 1'b1;
          break;
        end
      end
      if (!hit) begin
        o.status = ST_MISSING;
        pos      = 0;
      end else begin
        for (int i = pos; i + 1 < shadow_cnt; i++) shadow_tbl[i] = shadow_tbl[i+1];
        shadow_cnt--;
      end
    end
    o.position    = pos[PW-1:0];
    o.entry_count = shadow_cnt[PW-1:0];
    return o;
  endfunction

  // Offer one beat, hold it until taken, then log what it should return.
  task automatic send_beat(input logic act, input logic [VW-1:0] val, input bit known,
                           input res_t known_res);
    req_t r;
    res_t pred;
    int   gap;
    r.action = act;
    r.value  = val;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1) ? $urandom_range(1, 4) : $urandom_range(1, 300);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= r;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pred = table_apply(r);
    pending_res_q.push_back(known ? known_res : pred);
    if (act == ACT_INSERT) n_insert++;
    else n_delete++;
    if (shadow_cnt > peak_cnt) peak_cnt = shadow_cnt;
  endtask

  always @(posedge clk_i) begin : res_check
    res_t want;
    if (rst_ni && res_valid_o === 1'b1) begin
      if (res_o.status == ST_FULL) n_full++;
      if (res_o.status == ST_MISSING) n_missing++;
      if (pending_res_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: status %0d position %0d count %0d", $realtime,
                   res_o.status, res_o.position, res_o.entry_count);
      end else begin
        want = pending_res_q.pop_front();
        if (res_o.status !== want.status || res_o.position !== want.position ||
            res_o.entry_count !== want.entry_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] result mismatch: exp status %0d pos %0d count %0d, got %0d %0d %0d",
                     $realtime, want.status, want.position, want.entry_count,
                     res_o.status, res_o.position, res_o.entry_count);
        end
      end
    end
  end

  initial begin
    res_t          row_res;
    logic          act;
    logic [VW-1:0] val;
    int            left;
    int            seg;
    int            bias;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      row_res.status      = dir_tab[i].st;
      row_res.position    = dir_tab[i].pos;
      row_res.entry_count = dir_tab[i].cnt;
      send_beat(dir_tab[i].act, dir_tab[i].val, dir_tab[i].known, row_res);
    end

    for (int ph = 0; ph < N_PHASE; ph++) begin
      idle_pct = PHASE_IDLE[ph];
      left     = PHASE_BEATS;
      while (left > 0) begin
        // Each stretch leans toward filling, stays balanced or leans toward draining, so both ends of the table get hit
        case ($urandom_range(2))
          0:       bias = 92;
          1:       bias = 50;
          default: bias = 12;
        endcase
        seg = $urandom_range(40, 250);
        for (int k = 0; k < seg && left > 0; k++) begin
          act = ($urandom_range(99) < bias) ? ACT_INSERT : ACT_DELETE;
          case ($urandom_range(3))
            0: val = $urandom;
            1: val = $urandom_range(16) - 8;
            2: val = EDGE_VALS[$urandom_range(3)];
            default: val = $urandom;
          endcase
          // Deletes mostly target stored values; inserts often duplicate them
          if (shadow_cnt > 0 && (act == ACT_DELETE ? $urandom_range(3) != 0
                                                   : $urandom_range(3) == 0))
            val = shadow_tbl[$urandom_range(shadow_cnt - 1)];
          send_beat(act, val, 1'b0, '0);
          left--;
        end
      end
      if (ph == 1) begin
        start_i <= 1'b0;
        while (pending_res_q.size() != 0) @(posedge clk_i);
      end
    end

    start_i <= 1'b0;
    while (pending_res_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    mismatches += pending_res_q.size();

    $display("Ran %0d inserts and %0d deletes; %0d hit a full table, %0d missed their value",
             n_insert, n_delete, n_full, n_missing);
    $display("Table occupancy peaked at %0d of %0d entries", peak_cnt, DEPTH);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d bad results", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
